// ----- rtl/core/hmm_forward_step_unit_macros.svh -----
// ----------------------------------------------------------------------------
// hmm_forward_step_unit_macros: assertion helpers of the forward step unit
// Clocked implication checks shared by the RTL, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef HMM_FORWARD_STEP_UNIT_MACROS_SVH
`define HMM_FORWARD_STEP_UNIT_MACROS_SVH

// Implication in the same cycle, sampled on clk, quiet during reset.
`define HFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the following cycle.
`define HFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/hfs_pkg.sv -----
// ----------------------------------------------------------------------------
// hfs_pkg: shared types and constants of the HMM forward step unit
// Default sizes, Q1.31 one, action codes, sequencer states, cell control.
// ----------------------------------------------------------------------------
package hfs_pkg;

    localparam int STATES_MAX_DEF  = 64;
    localparam int SYMBOLS_MAX_DEF = 64;

    // 1.0 in unsigned Q1.31
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // action codes of an input beat
    localparam logic [1:0] ACT_LOAD_INIT  = 2'd0;
    localparam logic [1:0] ACT_LOAD_TRANS = 2'd1;
    localparam logic [1:0] ACT_LOAD_EMIS  = 2'd2;
    localparam logic [1:0] ACT_OBSERVE    = 2'd3;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_SWEEP = 8'b0000_0010,
        ST_DRAIN = 8'b0000_0100,
        ST_MULT  = 8'b0000_1000,
        ST_STORE = 8'b0001_0000,
        ST_NORM  = 8'b0010_0000,
        ST_NWAIT = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } fsm_t;

    // shift strobes for the alpha cell chain
    typedef struct packed {
        logic shift_now;
        logic shift_next;
    } cell_ctrl_t;

endpackage

// ----- rtl/core/hfs_if.sv -----
// ----------------------------------------------------------------------------
// hfs_if: valid/ready channels of the HMM forward step unit
// Input beat, result beat and the state count write channel.
// ----------------------------------------------------------------------------
interface hfs_obs_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] prob;
    logic [5:0]  symbol;
    logic        first;

    modport source (output valid, action, row, col, prob, symbol, first, input ready);
    modport sink   (input valid, action, row, col, prob, symbol, first, output ready);
endinterface

interface hfs_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] scale;
    logic        all_zero;

    modport source (output valid, scale, all_zero, input ready);
    modport sink   (input valid, scale, all_zero, output ready);
endinterface

interface hfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/hfs_ram.sv -----
// ----------------------------------------------------------------------------
// hfs_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/hfs_cell.sv -----
// ----------------------------------------------------------------------------
// hfs_cell: one alpha cell of the state chain
// Holds the current and the next alpha of one state; shifts toward the head.
// ----------------------------------------------------------------------------
module hfs_cell
    import hfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  logic [31:0] now_in,
    input  logic [31:0] next_in,
    output logic [31:0] now_out,
    output logic [31:0] next_out
);

    logic [31:0] now_reg;
    logic [31:0] next_reg;

    // both alpha words reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg  <= '0;
            next_reg <= '0;
        end
        else
        begin
            if (ctrl.shift_now)
            begin
                now_reg <= now_in;
            end
            if (ctrl.shift_next)
            begin
                next_reg <= next_in;
            end
        end
    end

    assign now_out  = now_reg;
    assign next_out = next_reg;

endmodule

// ----- rtl/core/hfs_div.sv -----
// ----------------------------------------------------------------------------
// hfs_div: serial normalizing divider
// q = floor(num * 2^31 / den) for num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hfs_div #(
    parameter int SUMW = 38
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [31:0]     num,
    input  logic [SUMW-1:0] den,
    output logic            done,
    output logic [31:0]     q
);

    logic            busy_reg;
    logic            done_reg;
    logic [4:0]      cnt_reg;
    logic [SUMW-1:0] rem_reg;
    logic [31:0]     q_reg;
    logic [SUMW:0]   trial;
    logic            ge;

    // first step compares num itself, later steps the doubled remainder
    always_comb
    begin
        if (cnt_reg == 5'd0)
        begin
            trial = {1'b0, rem_reg};
        end
        else
        begin
            trial = {rem_reg, 1'b0};
        end
        ge = (trial >= {1'b0, den});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= SUMW'(num);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= SUMW'(trial - {1'b0, den});
            end
            else
            begin
                rem_reg <= SUMW'(trial);
            end
            q_reg <= {q_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ----- rtl/core/hmm_forward_step_unit.sv -----
// ----------------------------------------------------------------------------
// hmm_forward_step_unit: scaled HMM forward recursion, Q1.31
// Table loads, one forward step per observed symbol, scale factor out.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | note
//  obs     | in  | action, row, col, prob, symbol, first    | loads and symbols
//  res     | out | scale, all_zero                          | one per symbol
//  cfg     | in  | data (state count)                       | always ready
//
// Loads are taken back to back. A continuation symbol runs a multiply-accumulate
// sweep over all STATES_MAX source states for every one of the STATES_MAX target
// states, one product per cycle through the shared multiplier, then a serial
// division for the normalization; a first symbol skips the transition sweep.
// Reset clears the alpha chain and sets the state count to 1. A stalled
// result holds in its register; a finished step then waits for it.
// ----------------------------------------------------------------------------
`include "hmm_forward_step_unit_macros.svh"

module hmm_forward_step_unit
    import hfs_pkg::*;
#(
    parameter int STATES_MAX  = STATES_MAX_DEF,
    parameter int SYMBOLS_MAX = SYMBOLS_MAX_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    hfs_obs_if.sink obs,
    hfs_res_if.source res,
    hfs_cfg_if.sink cfg
);

    localparam int IW   = $clog2(STATES_MAX);
    localparam int NW   = $clog2(STATES_MAX + 1);
    localparam int TAW  = $clog2(STATES_MAX * STATES_MAX);
    localparam int EAW  = $clog2(STATES_MAX * SYMBOLS_MAX);
    localparam int SUMW = 32 + $clog2(STATES_MAX);

    fsm_t            state_reg;
    logic [6:0]      state_count_reg;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   k_reg;
    logic [NW-1:0]   n_reg;
    logic            first_reg;
    logic [5:0]      sym_reg;
    logic [63:0]     acc_reg;
    logic [SUMW-1:0] sum_reg;
    logic [31:0]     a_d_reg;
    logic            kv_reg;
    logic            v1_reg;
    logic            v2_reg;
    logic [63:0]     prod_reg;
    logic            res_valid_reg;
    logic [31:0]     res_scale_reg;
    logic            res_zero_reg;

    logic            accept;
    logic [31:0]     prob_sat;
    logic [NW-1:0]   n_cfg;
    logic            tr_we;
    logic            em_we;
    logic            in_we;
    logic [TAW-1:0]  tr_waddr;
    logic [TAW-1:0]  tr_raddr;
    logic [EAW-1:0]  em_waddr;
    logic [EAW-1:0]  em_raddr;
    logic [31:0]     tr_rdata;
    logic [31:0]     em_rdata;
    logic [31:0]     in_rdata;
    logic [31:0]     em_sel;
    logic [32:0]     acc_hi;
    logic [31:0]     base;
    logic [31:0]     mul_a;
    logic [31:0]     mul_b;
    logic [64:0]     acc_sum;
    logic [31:0]     store_val;
    logic            i_active;
    logic            i_last;
    logic            k_last;
    logic            norm_trivial;
    logic            norm_push;
    logic [31:0]     norm_val;
    logic            div_start;
    logic            div_done;
    logic [31:0]     div_q;
    logic            out_load;
    logic [31:0]     now_tail;
    logic [31:0]     next_tail;
    cell_ctrl_t      cell_ctrl;
    logic [31:0]     now_w  [STATES_MAX];
    logic [31:0]     next_w [STATES_MAX];

    // handshakes
    assign obs.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = obs.valid && obs.ready;

    // load decode: saturate prob, drop out-of-range indexes
    assign prob_sat = (obs.prob > ONE_Q31) ? ONE_Q31 : obs.prob;
    assign in_we    = accept && (obs.action == ACT_LOAD_INIT) && (int'(obs.row) < STATES_MAX);
    assign tr_we    = accept && (obs.action == ACT_LOAD_TRANS)
                      && (int'(obs.row) < STATES_MAX) && (int'(obs.col) < STATES_MAX);
    assign em_we    = accept && (obs.action == ACT_LOAD_EMIS)
                      && (int'(obs.row) < STATES_MAX) && (int'(obs.col) < SYMBOLS_MAX);
    assign tr_waddr = TAW'(TAW'(obs.row) * TAW'(STATES_MAX) + TAW'(obs.col));
    assign em_waddr = EAW'(EAW'(obs.row) * EAW'(SYMBOLS_MAX) + EAW'(obs.col));

    // sweep and emission read addresses
    assign tr_raddr = TAW'(TAW'(k_reg) * TAW'(STATES_MAX) + TAW'(i_reg));
    assign em_raddr = EAW'(EAW'(i_reg) * EAW'(SYMBOLS_MAX) + EAW'(sym_reg));

    hfs_ram #(.WIDTH(32), .DEPTH(STATES_MAX * STATES_MAX)) u_tr_ram (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (prob_sat),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    hfs_ram #(.WIDTH(32), .DEPTH(STATES_MAX * SYMBOLS_MAX)) u_em_ram (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (prob_sat),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    hfs_ram #(.WIDTH(32), .DEPTH(STATES_MAX)) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (IW'(obs.row)),
        .wdata (prob_sat),
        .raddr (i_reg),
        .rdata (in_rdata)
    );

    // active state count, clamped to 1..STATES_MAX
    always_comb
    begin
        if (state_count_reg == 7'd0)
        begin
            n_cfg = NW'(1);
        end
        else if (int'(state_count_reg) > STATES_MAX)
        begin
            n_cfg = NW'(STATES_MAX);
        end
        else
        begin
            n_cfg = NW'(state_count_reg);
        end
    end

    // per-state arithmetic; transition words of unused source states read as zero
    assign em_sel   = (int'(sym_reg) < SYMBOLS_MAX) ? em_rdata : 32'd0;
    assign acc_hi   = acc_reg[63:31];
    assign base     = first_reg ? in_rdata
                      : ((acc_hi > {1'b0, ONE_Q31}) ? ONE_Q31 : acc_hi[31:0]);
    assign mul_a    = (state_reg == ST_MULT) ? base : a_d_reg;
    assign mul_b    = (state_reg == ST_MULT) ? em_sel : (kv_reg ? tr_rdata : 32'd0);
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, prod_reg};
    assign i_active = (NW'(i_reg) < n_reg);
    assign i_last   = (i_reg == IW'(STATES_MAX - 1));
    assign k_last   = (k_reg == IW'(STATES_MAX - 1));
    assign store_val = i_active ? prod_reg[62:31] : 32'd0;

    // normalization
    assign norm_trivial = (sum_reg == '0) || !i_active;
    assign div_start    = (state_reg == ST_NORM) && !norm_trivial;
    assign norm_push    = ((state_reg == ST_NORM) && norm_trivial)
                          || ((state_reg == ST_NWAIT) && div_done);
    assign norm_val     = (state_reg == ST_NWAIT) ? div_q : 32'd0;
    assign out_load     = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);

    hfs_div #(.SUMW(SUMW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (next_w[0]),
        .den   (sum_reg),
        .done  (div_done),
        .q     (div_q)
    );

    // alpha chain: now rotates during the sweep, takes quotients in normalization
    assign now_tail  = (state_reg == ST_SWEEP) ? now_w[0] : norm_val;
    assign next_tail = (state_reg == ST_STORE) ? store_val : 32'd0;
    assign cell_ctrl.shift_now  = (state_reg == ST_SWEEP) || norm_push;
    assign cell_ctrl.shift_next = (state_reg == ST_STORE) || norm_push;

    for (genvar j = 0; j < STATES_MAX; j++)
    begin : g_cell
        if (j == STATES_MAX - 1)
        begin : g_tail
            hfs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .now_in   (now_tail),
                .next_in  (next_tail),
                .now_out  (now_w[j]),
                .next_out (next_w[j])
            );
        end
        else
        begin : g_body
            hfs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .now_in   (now_w[j+1]),
                .next_in  (next_w[j+1]),
                .now_out  (now_w[j]),
                .next_out (next_w[j])
            );
        end
    end

    // sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            state_count_reg <= 7'd1;
            i_reg           <= '0;
            k_reg           <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                state_count_reg <= cfg.data;
            end
            v1_reg <= (state_reg == ST_SWEEP);
            v2_reg <= v1_reg;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (obs.action == ACT_OBSERVE))
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= obs.first ? ST_DRAIN : ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    k_reg <= k_last ? '0 : k_reg + IW'(1);
                    if (k_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= ST_MULT;
                    end
                end
                ST_MULT:
                begin
                    state_reg <= ST_STORE;
                end
                ST_STORE:
                begin
                    if (i_last)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_NORM;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IW'(1);
                        state_reg <= first_reg ? ST_DRAIN : ST_SWEEP;
                    end
                end
                ST_NORM, ST_NWAIT:
                begin
                    if (norm_push)
                    begin
                        if (i_last)
                        begin
                            i_reg     <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= ST_NORM;
                        end
                    end
                    else if (state_reg == ST_NORM)
                    begin
                        state_reg <= ST_NWAIT;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && (obs.action == ACT_OBSERVE))
        begin
            first_reg <= obs.first;
            sym_reg   <= obs.symbol;
            n_reg     <= n_cfg;
            sum_reg   <= '0;
        end
        a_d_reg  <= (NW'(k_reg) < n_reg) ? now_w[0] : 32'd0;
        kv_reg   <= (NW'(k_reg) < n_reg);
        prod_reg <= mul_a * mul_b;
        if ((state_reg == ST_IDLE) || (state_reg == ST_STORE))
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_sum[64] ? '1 : acc_sum[63:0];
        end
        if (state_reg == ST_STORE)
        begin
            sum_reg <= sum_reg + SUMW'(store_val);
        end
        if (out_load)
        begin
            res_scale_reg <= (sum_reg > SUMW'(ONE_Q31)) ? ONE_Q31 : sum_reg[31:0];
            res_zero_reg  <= (sum_reg == '0);
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.scale    = res_scale_reg;
    assign res.all_zero = res_zero_reg;

    // checks
    `HFS_ASSERT_NEXT(a_obs_starts, accept && (obs.action == ACT_OBSERVE), state_reg != ST_IDLE, "observe beat did not start a step")
    `HFS_ASSERT_NOW(a_mult_drained, state_reg == ST_MULT, !v1_reg && !v2_reg, "final multiply with products in flight")
    `HFS_ASSERT_NOW(a_quot_range, (state_reg == ST_NWAIT) && div_done, div_q <= ONE_Q31, "normalized alpha above one")

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the HMM forward step unit
// Table loads and observed symbols go in through a queued driver with
// random gaps. A scaled forward recursion in the bench predicts every
// scale beat, and a monitor compares each result beat with the oldest
// prediction. The state count is rewritten between phases while the unit
// is idle.
// ----------------------------------------------------------------------------
module testbench;
    import hfs_pkg::*;

    localparam int NS             = STATES_MAX_DEF;
    localparam int NSYM           = SYMBOLS_MAX_DEF;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        logic [1:0]  action;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] prob;
        logic [5:0]  symbol;
        logic        first;
    } obs_beat_t;

    typedef struct {
        logic [31:0] scale;
        logic        all_zero;
    } scale_beat_t;

    logic clk;
    logic rst_n;

    hfs_obs_if obs_ch ();
    hfs_res_if res_ch ();
    hfs_cfg_if cfg_ch ();

    hmm_forward_step_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .obs   (obs_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    obs_beat_t   pending_beats[$];
    scale_beat_t expected_scales[$];
    int          mismatches;
    bit          burst;

    // generator view: which table entries have been loaded so far
    bit gen_init_ok  [NS];
    bit gen_trans_ok [NS*NS];
    bit gen_emis_ok  [NS*NSYM];
    int gen_states;

    // bench copy of the unit state
    bit [31:0] init_tab  [NS];
    bit [31:0] trans_tab [NS*NS];
    bit [31:0] emis_tab  [NS*NSYM];
    bit [31:0] alpha_cur [NS];
    bit [31:0] alpha_raw [NS];
    int        model_states;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_states(int v);
        if (v == 0)
            return 1;
        if (v > NS)
            return NS;
        return v;
    endfunction

    function automatic logic [31:0] rand_prob();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return ONE_Q31;
            2: return $urandom();
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    // scaled forward recursion on one accepted input beat
    function automatic void forward_step(obs_beat_t b);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] acc;
        logic [63:0] prod;
        logic [63:0] base;
        logic [63:0] em;
        scale_beat_t r;
        p = (b.prob > ONE_Q31) ? 64'(ONE_Q31) : 64'(b.prob);
        case (b.action)
            ACT_LOAD_INIT:  init_tab[b.row] = p[31:0];
            ACT_LOAD_TRANS: trans_tab[b.row*NS + b.col] = p[31:0];
            ACT_LOAD_EMIS:  emis_tab[b.row*NSYM + b.col] = p[31:0];
            default:
            begin
                sum = 0;
                for (int i = 0; i < NS; i++)
                begin
                    if (i >= model_states)
                    begin
                        alpha_raw[i] = 0;
                        continue;
                    end
                    em = 64'(emis_tab[i*NSYM + b.symbol]);
                    if (b.first)
                        base = 64'(init_tab[i]);
                    else
                    begin
                        acc = 0;
                        for (int k = 0; k < model_states; k++)
                        begin
                            prod = 64'(alpha_cur[k]) * 64'(trans_tab[k*NS + i]);
                            acc = (acc > ~64'd0 - prod) ? ~64'd0 : acc + prod;
                        end
                        base = acc >> 31;
                        if (base > 64'(ONE_Q31))
                            base = 64'(ONE_Q31);
                    end
                    alpha_raw[i] = 32'((base * em) >> 31);
                    sum += 64'(alpha_raw[i]);
                end
                for (int i = 0; i < NS; i++)
                begin
                    if (sum == 0 || i >= model_states)
                        alpha_cur[i] = 0;
                    else
                        alpha_cur[i] = 32'((64'(alpha_raw[i]) << 31) / sum);
                end
                r.scale    = (sum > 64'(ONE_Q31)) ? ONE_Q31 : sum[31:0];
                r.all_zero = (sum == 0);
                expected_scales.push_back(r);
            end
        endcase
    endfunction

    // queue a load beat and note the entry as written
    function automatic void push_load(logic [1:0] act, int r, int c, logic [31:0] p);
        obs_beat_t b;
        b.action = act;
        b.row    = 6'(r);
        b.col    = 6'(c);
        b.prob   = p;
        b.symbol = 6'($urandom_range(0, 63));
        b.first  = 1'($urandom_range(0, 1));
        case (act)
            ACT_LOAD_INIT:  gen_init_ok[r] = 1'b1;
            ACT_LOAD_TRANS: gen_trans_ok[r*NS + c] = 1'b1;
            default:        gen_emis_ok[r*NSYM + c] = 1'b1;
        endcase
        pending_beats.push_back(b);
    endfunction

    // queue a symbol, preceded by loads of any table entry it would read unwritten
    function automatic void push_observe(int sym, bit first);
        obs_beat_t b;
        for (int i = 0; i < gen_states; i++)
        begin
            if (!gen_emis_ok[i*NSYM + sym])
                push_load(ACT_LOAD_EMIS, i, sym, rand_prob());
            if (first && !gen_init_ok[i])
                push_load(ACT_LOAD_INIT, i, 0, rand_prob());
            for (int k = 0; k < gen_states && !first; k++)
                if (!gen_trans_ok[k*NS + i])
                    push_load(ACT_LOAD_TRANS, k, i, rand_prob());
        end
        b.action = ACT_OBSERVE;
        b.row    = 6'($urandom_range(0, 63));
        b.col    = 6'($urandom_range(0, 63));
        b.prob   = $urandom();
        b.symbol = 6'(sym);
        b.first  = first;
        pending_beats.push_back(b);
    endfunction

    // random sequences with a little load noise; counts symbols and noise loads
    function automatic void random_traffic(int beats);
        int done_beats;
        int len;
        int sym;
        done_beats = 0;
        while (done_beats < beats)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                push_load(2'($urandom_range(0, 2)), $urandom_range(0, 63),
                          $urandom_range(0, 63), rand_prob());
                done_beats++;
            end
            else
            begin
                len = $urandom_range(1, 4);
                for (int s = 0; s < len; s++)
                begin
                    sym = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, 3);
                    push_observe(sym, s == 0);
                end
                done_beats += len;
            end
        end
    endfunction

    // wait until every beat went in and every result came out
    task automatic drain();
        while (pending_beats.size() != 0 || obs_ch.valid || expected_scales.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_state_count(int v);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= 7'(v);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        gen_states = clamp_states(v);
    endtask

    // stall pattern: occasionally switch between gappy and back-to-back traffic
    always @(posedge clk)
    begin
        if ($urandom_range(0, 149) == 0)
            burst <= ~burst;
    end

    // input driver
    int        send_gap;
    obs_beat_t next_beat;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_ch.valid  <= 1'b0;
            obs_ch.action <= '0;
            obs_ch.row    <= '0;
            obs_ch.col    <= '0;
            obs_ch.prob   <= '0;
            obs_ch.symbol <= '0;
            obs_ch.first  <= 1'b0;
            send_gap      <= 0;
        end
        else if (!obs_ch.valid || obs_ch.ready)
        begin
            if (send_gap > 0)
            begin
                obs_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end
            else if (pending_beats.size() != 0)
            begin
                next_beat      = pending_beats.pop_front();
                obs_ch.action <= next_beat.action;
                obs_ch.row    <= next_beat.row;
                obs_ch.col    <= next_beat.col;
                obs_ch.prob   <= next_beat.prob;
                obs_ch.symbol <= next_beat.symbol;
                obs_ch.first  <= next_beat.first;
                obs_ch.valid  <= 1'b1;
                send_gap      <= burst ? 0 : $urandom_range(0, 3);
            end
            else
                obs_ch.valid <= 1'b0;
        end
    end

    // result ready with random stalls
    int res_hold;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            res_hold     <= 0;
        end
        else if (res_ch.ready)
        begin
            if (res_ch.valid && !burst && $urandom_range(0, 1))
            begin
                res_ch.ready <= 1'b0;
                res_hold     <= $urandom_range(0, 2);
            end
        end
        else if (res_hold > 0)
            res_hold <= res_hold - 1;
        else
            res_ch.ready <= 1'b1;
    end

    // monitor: predict on input beats, check result beats
    scale_beat_t want;
    obs_beat_t   next_beat_seen;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                model_states = clamp_states(int'(cfg_ch.data));
            if (obs_ch.valid && obs_ch.ready)
            begin
                next_beat_seen.action = obs_ch.action;
                next_beat_seen.row    = obs_ch.row;
                next_beat_seen.col    = obs_ch.col;
                next_beat_seen.prob   = obs_ch.prob;
                next_beat_seen.symbol = obs_ch.symbol;
                next_beat_seen.first  = obs_ch.first;
                forward_step(next_beat_seen);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_scales.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with none expected: scale %h all_zero %b",
                                 res_ch.scale, res_ch.all_zero);
                end
                else
                begin
                    want = expected_scales.pop_front();
                    if (res_ch.scale !== want.scale || res_ch.all_zero !== want.all_zero)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: scale exp %h got %h, all_zero exp %b got %b",
                                     want.scale, res_ch.scale, want.all_zero,
                                     res_ch.all_zero);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any beat
    int idle_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (obs_ch.valid && obs_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL hmm_forward_step_unit");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        burst        = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;
        model_states = 1;
        gen_states   = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // continuation straight after reset, alpha still zero
        push_load(ACT_LOAD_TRANS, 0, 0, ONE_Q31);
        push_load(ACT_LOAD_EMIS, 0, 5, ONE_Q31);
        push_observe(5, 1'b0);
        // probability above one saturates; full start and continuation
        push_load(ACT_LOAD_INIT, 0, 0, 32'hFFFF_FFFF);
        push_observe(5, 1'b1);
        push_observe(5, 1'b0);
        // zero emission masks the only state
        push_load(ACT_LOAD_EMIS, 0, 63, 32'd0);
        push_observe(63, 1'b1);
        push_load(ACT_LOAD_EMIS, 63, 63, 32'h0000_0001);
        push_load(ACT_LOAD_TRANS, 63, 63, 32'h8000_0001);
        push_load(ACT_LOAD_INIT, 63, 0, 32'd0);
        drain();

        // count register zero acts as one
        write_state_count(0);
        push_observe(5, 1'b1);
        random_traffic(6);
        drain();

        // small sizes carry all of the random traffic; one mid-phase pause
        write_state_count(2);
        random_traffic(12);
        drain();
        random_traffic(8);
        drain();

        write_state_count(3);
        random_traffic(12);
        drain();

        write_state_count(1);
        random_traffic(8);
        drain();

        write_state_count(5);
        random_traffic(8);
        drain();

        write_state_count(4);
        random_traffic(8);
        drain();

        if (mismatches == 0)
            $display("PASS hmm_forward_step_unit");
        else
            $display("FAIL hmm_forward_step_unit");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/hfs_pkg.sv
rtl/core/hfs_if.sv
rtl/core/hfs_ram.sv
rtl/core/hfs_cell.sv
rtl/core/hfs_div.sv
rtl/core/hmm_forward_step_unit.sv
tb/testbench.sv
